FILE: rtl/nwmh_pkg.sv
// Package for the n-gram word hash core: widths, hash constants, shared types
// and rotate helpers. No dependencies.
`default_nettype none

package nwmh_pkg;

	localparam int unsigned WORD_W = 32;

	localparam logic [WORD_W-1:0] SEED_RESET = 32'd17;
	localparam logic [WORD_W-1:0] MIX_C1     = 32'hcc9e2d51;
	localparam logic [WORD_W-1:0] MIX_C2     = 32'h1b873593;
	localparam logic [WORD_W-1:0] FOLD_ADD   = 32'he6546b64;
	localparam logic [WORD_W-1:0] FIN_C1     = 32'h85ebca6b;
	localparam logic [WORD_W-1:0] FIN_C2     = 32'hc2b2ae35;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX1,
		ST_MIX2,
		ST_FOLD,
		ST_FIN1,
		ST_FIN2,
		ST_FIN3
	} state_t;

	// Operand selection for the shared multiplier
	typedef enum logic [1:0] {
		MUL_MIX1,
		MUL_MIX2,
		MUL_FIN1,
		MUL_FIN2
	} mul_op_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic    load_word;
		logic    mul_en;
		mul_op_t mul_op;
		logic    fold;
		logic    load_out;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic last;
	} dp_status_t;

	function automatic logic [WORD_W-1:0] rotl15(input logic [WORD_W-1:0] v);
		return {v[WORD_W-16:0], v[WORD_W-1:WORD_W-15]};
	endfunction

	function automatic logic [WORD_W-1:0] rotl13(input logic [WORD_W-1:0] v);
		return {v[WORD_W-14:0], v[WORD_W-1:WORD_W-13]};
	endfunction

endpackage

`default_nettype wire

FILE: rtl/nwmh_if.sv
// Valid/ready channel interfaces for the word input and the hash output.
// Depends on nwmh_pkg for the word width.
`default_nettype none

interface nwmh_word_if import nwmh_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] word_index;
	logic              last_word;

	modport source (output valid, output word_index, output last_word, input ready);
	modport sink (input valid, input word_index, input last_word, output ready);
endinterface

interface nwmh_hash_if import nwmh_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] hash_value;

	modport source (output valid, output hash_value, input ready);
	modport sink (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/nwmh_datapath.sv
// Datapath of the n-gram word hash: seed register, running hash and count,
// one shared 32x32 multiplier and the output hash register. Uses nwmh_pkg.
`default_nettype none

module nwmh_datapath import nwmh_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_cmd_t           cmd,
	output      dp_status_t        status,
	input  wire logic [WORD_W-1:0] word_index,
	input  wire logic              last_word,
	input  wire logic              cfg_wr_en,
	input  wire logic [WORD_W-1:0] cfg_wr_data,
	output      logic [WORD_W-1:0] hash_value
);

	logic [WORD_W-1:0] seed_q;
	logic [WORD_W-1:0] word_q;
	logic              last_q;
	logic [WORD_W-1:0] prod_q;
	logic [WORD_W-1:0] hash_q;
	logic [WORD_W-1:0] count_q;
	logic              mid_q;
	logic [WORD_W-1:0] out_q;

	logic [WORD_W-1:0] mul_a;
	logic [WORD_W-1:0] mul_b;
	logic [WORD_W-1:0] mul_p;
	logic [WORD_W-1:0] fin_x;
	logic [WORD_W-1:0] fold_in;
	logic [WORD_W-1:0] fold_rot;
	logic [WORD_W-1:0] hash_nxt;
	logic [WORD_W-1:0] count_nxt;

	// Seed register and the flag that an n-gram is in progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
			mid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				seed_q <= cfg_wr_data;
			end
			if (cmd.fold) begin
				mid_q <= ~last_q;
			end
		end
	end

	// Select multiplier operands for the current step
	always_comb begin
		fin_x = hash_q ^ count_q;
		unique case (cmd.mul_op)
			MUL_MIX1: begin
				mul_a = word_q;
				mul_b = MIX_C1;
			end
			MUL_MIX2: begin
				mul_a = rotl15(prod_q);
				mul_b = MIX_C2;
			end
			MUL_FIN1: begin
				mul_a = fin_x ^ (fin_x >> 16);
				mul_b = FIN_C1;
			end
			MUL_FIN2: begin
				mul_a = prod_q ^ (prod_q >> 13);
				mul_b = FIN_C2;
			end
			default: begin
				mul_a = word_q;
				mul_b = MIX_C1;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// Fold the mixed word into the running hash: xor, rotate, times 5 plus constant
	always_comb begin
		fold_in   = (mid_q ? hash_q : seed_q) ^ prod_q;
		fold_rot  = rotl13(fold_in);
		hash_nxt  = fold_rot + {fold_rot[WORD_W-3:0], 2'b00} + FOLD_ADD;
		count_nxt = (mid_q ? count_q : '0) + WORD_W'(1);
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_word) begin
			word_q <= word_index;
			last_q <= last_word;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_p;
		end
		if (cmd.fold) begin
			hash_q  <= hash_nxt;
			count_q <= count_nxt;
		end
		if (cmd.load_out) begin
			out_q <= prod_q ^ (prod_q >> 16);
		end
	end

	assign status.last = last_q;
	assign hash_value  = out_q;

endmodule

`default_nettype wire

FILE: rtl/nwmh_ctrl.sv
// Controller of the n-gram word hash: sequences mix, fold and finalization
// steps and owns both channel handshakes. Uses nwmh_pkg.
`default_nettype none

module nwmh_ctrl import nwmh_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       word_valid,
	output      logic       word_ready,
	output      logic       hash_valid,
	input  wire logic       hash_ready,
	input  wire dp_status_t status,
	output      dp_cmd_t    cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	// State register and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (hash_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_nxt     = state_q;
		word_ready    = 1'b0;
		cmd.load_word = 1'b0;
		cmd.mul_en    = 1'b0;
		cmd.mul_op    = MUL_MIX1;
		cmd.fold      = 1'b0;
		cmd.load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				word_ready = 1'b1;
				if (word_valid) begin
					cmd.load_word = 1'b1;
					state_nxt     = ST_MIX1;
				end
			end
			ST_MIX1: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_MIX1;
				state_nxt  = ST_MIX2;
			end
			ST_MIX2: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_MIX2;
				state_nxt  = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.fold  = 1'b1;
				state_nxt = status.last ? ST_FIN1 : ST_IDLE;
			end
			ST_FIN1: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_FIN1;
				state_nxt  = ST_FIN2;
			end
			ST_FIN2: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_FIN2;
				state_nxt  = ST_FIN3;
			end
			ST_FIN3: begin
				// hold until the output register is free
				if (!out_valid_q || hash_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign hash_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/ngram_word_murmur_hash_core.sv
// N-gram word hash core (MurmurHash3 x86_32 style, word-count finalization).
// Steps: a word is taken in IDLE, then MIX1, MIX2 and FOLD run; a last word
// adds FIN1..FIN3, and FIN3 loads its hash into the output register.
// One shared multiplier serves all steps, so a new word is taken only in IDLE
// after those steps end; FIN3 holds while the old hash still waits on the output.
// Reset: arst_n clears the controller, the n-gram flag and loads seed 17.
`default_nettype none

module ngram_word_murmur_hash_core import nwmh_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	nwmh_word_if.sink              word_ch,
	nwmh_hash_if.source            hash_ch,
	input  wire logic              cfg_wr_en,
	input  wire logic [WORD_W-1:0] cfg_wr_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	nwmh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_ch.valid),
		.word_ready (word_ch.ready),
		.hash_valid (hash_ch.valid),
		.hash_ready (hash_ch.ready),
		.status     (status),
		.cmd        (cmd)
	);

	nwmh_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.word_index  (word_ch.word_index),
		.last_word   (word_ch.last_word),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.hash_value  (hash_ch.hash_value)
	);

endmodule

`default_nettype wire

FILE: rtl/nwmh_checker.sv
// Port-level checker for the n-gram word hash core, bound to the top level.
// Depends on nwmh_pkg and ngram_word_murmur_hash_core.
`default_nettype none

module nwmh_checker import nwmh_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              word_valid,
	input wire logic              word_ready,
	input wire logic              last_word,
	input wire logic              hash_valid,
	input wire logic              hash_ready,
	input wire logic [WORD_W-1:0] hash_value
);

	// A stalled result holds valid
	assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid && !hash_ready |=> hash_valid)
		else $error("hash item dropped while stalled");

	// A stalled result holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid && !hash_ready |=> $stable(hash_value))
		else $error("hash value changed while stalled");

	// An accepted item blocks the input for the mix and fold steps
	assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word_ready |=> !word_ready ##1 !word_ready ##1 !word_ready)
		else $error("input taken during mix or fold");

	// A word that is not last makes no result
	assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word_ready && !last_word && !hash_valid
		|=> !hash_valid ##1 !hash_valid ##1 !hash_valid ##1 !hash_valid)
		else $error("result made without a last word");

endmodule

bind ngram_word_murmur_hash_core nwmh_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.word_valid (word_ch.valid),
	.word_ready (word_ch.ready),
	.last_word  (word_ch.last_word),
	.hash_valid (hash_ch.valid),
	.hash_ready (hash_ch.ready),
	.hash_value (hash_ch.hash_value)
);

`default_nettype wire
